### sv/fbpa_pkg.sv
package fbpa_pkg;

    localparam int unsigned IDX_W      = 12;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned OFFSET_W   = 24;
    localparam int unsigned SIZE_W     = 13;
    localparam int unsigned PAGE_CFG_W = 11;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned LINK_DEPTH = 4096;
    localparam int unsigned SIZE_LIMIT = 4096;
    localparam int unsigned COUNT_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUESTED_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_PAGE = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FREED     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NULL_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NO_MEMORY = 2'd3;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_NULL  = 2'd2
    } fbpa_kind_t;

    typedef struct packed {
        fbpa_kind_t       kind;
        logic [IDX_W-1:0] index;
    } fbpa_cmd_t;

endpackage

### sv/fbpa_if.sv
interface fbpa_req_if
    import fbpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic             pointer_present;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, output opcode, output pointer_present,
                    output block_index, input ready);
    modport sink   (input valid, input opcode, input pointer_present,
                    input block_index, output ready);
endinterface

interface fbpa_rsp_if
    import fbpa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [OFFSET_W-1:0] byte_offset;

    modport source (output valid, output status, output granted_index,
                    output byte_offset, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input byte_offset, output ready);
endinterface

### sv/fixed_block_pool_allocator_top.sv
// A response passes the command queue, a result register and an output register.
// Throughput: one request per cycle for frees and fresh allocations while the
//   response path does not stall; a recycled-list allocation also visits S_POP (link memory read).
// A two-entry queue decouples request intake from execution.
// Reset clears pool counters, list head and config to defaults; the link
//   memory is not cleared and needs no clearing pass.
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_PAGES     = 4,
    parameter int unsigned PAGE_BLOCKS   = 1024,
    parameter int unsigned POINTER_BYTES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fbpa_req_if.sink              req,
    fbpa_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      cmd_valid;
    logic      cmd_pop;
    fbpa_cmd_t cmd;

    fbpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    fbpa_back #(
        .MAX_PAGES     (MAX_PAGES),
        .PAGE_BLOCKS   (PAGE_BLOCKS),
        .POINTER_BYTES (POINTER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

### sv/fbpa_front.sv
module fbpa_front
    import fbpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fbpa_req_if.sink    req,
    output logic        cmd_valid,
    output fbpa_cmd_t   cmd,
    input  logic        cmd_pop
);

    localparam int unsigned QDEPTH = 2;

    fbpa_cmd_t  fifo_mem [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    fbpa_cmd_t  in_cmd;

    assign req.ready = (cnt_reg != 2'(QDEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        in_cmd.index = req.block_index;
        if (req.opcode == OP_FREE)
        begin
            in_cmd.kind = req.pointer_present ? KIND_FREE : KIND_NULL;
        end
        else
        begin
            in_cmd.kind = KIND_ALLOC;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### sv/fbpa_back.sv
module fbpa_back
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_PAGES     = 4,
    parameter int unsigned PAGE_BLOCKS   = 1024,
    parameter int unsigned POINTER_BYTES = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  cmd_valid,
    input  fbpa_cmd_t             cmd,
    output logic                  cmd_pop,
    fbpa_rsp_if.source            rsp
);

    localparam int unsigned PAGE_W  = $clog2(MAX_PAGES + 1);
    localparam int unsigned FRESH_W = $clog2(PAGE_BLOCKS + 1);
    localparam int unsigned SIZE_RST_RAW = (16 < POINTER_BYTES) ? POINTER_BYTES : 16;
    localparam int unsigned SIZE_RST =
        ((SIZE_RST_RAW + POINTER_BYTES - 1) / POINTER_BYTES) * POINTER_BYTES;
    localparam int unsigned PAGE_RST = (PAGE_BLOCKS < 1024) ? PAGE_BLOCKS : 1024;
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
    localparam int unsigned RND_SHIFT = 17;
    localparam int unsigned RND_RECIP =
        ((1 << RND_SHIFT) + POINTER_BYTES - 1) / POINTER_BYTES;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic [IDX_W-1:0] link_mem [LINK_DEPTH];
    logic [IDX_W-1:0] rd_data_reg;
    logic             mem_we;
    logic             mem_re;

    logic               state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FRESH_W-1:0] fresh_reg, fresh_next;
    logic [PAGE_W-1:0]  pages_reg, pages_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [FRESH_W-1:0] psize_reg, psize_next;

    logic                r_valid_reg, r_valid_next;
    logic [STATUS_W-1:0] r_status_reg, r_status_next;
    logic [IDX_W-1:0]    r_index_reg, r_index_next;
    logic                r_load;

    logic                o_valid_reg, o_valid_next;
    logic [STATUS_W-1:0] o_status_reg;
    logic [IDX_W-1:0]    o_index_reg;
    logic [OFFSET_W-1:0] o_offset_reg;

    logic                      adv;
    logic                      slot_free;
    logic [PAGE_W-1:0]         page_sel;
    logic [FRESH_W-1:0]        fresh_sel;
    logic [31:0]               fresh_sum;
    logic [IDX_W+SIZE_W-1:0]   prod;
    int unsigned               s_val;
    int unsigned               b_val;

    // config: adjusted size and clamped page size are held ready
    always_comb
    begin
        s_val = 32'(cfg_wdata);
        if (s_val > SIZE_LIMIT)
        begin
            s_val = SIZE_LIMIT;
        end
        if (s_val < POINTER_BYTES)
        begin
            s_val = POINTER_BYTES;
        end
        // round up to pointer alignment by reciprocal multiply
        s_val = s_val + POINTER_BYTES - 1;
        s_val = ((s_val * RND_RECIP) >> RND_SHIFT) * POINTER_BYTES;

        b_val = 32'(cfg_wdata[PAGE_CFG_W-1:0]);
        if (b_val < 1)
        begin
            b_val = 1;
        end
        if (b_val > PAGE_BLOCKS)
        begin
            b_val = PAGE_BLOCKS;
        end

        size_next  = size_reg;
        psize_next = psize_reg;
        if (cfg_we && (cfg_index == CFG_REQUESTED_SIZE))
        begin
            size_next = s_val[SIZE_W-1:0];
        end
        if (cfg_we && (cfg_index == CFG_BLOCKS_IN_PAGE))
        begin
            psize_next = b_val[FRESH_W-1:0];
        end
    end

    assign adv       = r_valid_reg && (!o_valid_reg || rsp.ready);
    assign slot_free = !r_valid_reg || adv;

    always_comb
    begin
        if (fresh_reg == '0)
        begin
            page_sel  = pages_reg;
            fresh_sel = psize_reg - FRESH_W'(1);
        end
        else
        begin
            page_sel  = pages_reg - PAGE_W'(1);
            fresh_sel = fresh_reg - FRESH_W'(1);
        end
        fresh_sum = 32'(page_sel) * 32'(PAGE_BLOCKS) + 32'(fresh_sel);
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        fresh_next    = fresh_reg;
        pages_next    = pages_reg;
        cmd_pop       = 1'b0;
        r_load        = 1'b0;
        r_status_next = r_status_reg;
        r_index_next  = r_index_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop       = 1'b1;
                    r_load        = 1'b1;
                    r_index_next  = '0;
                    case (cmd.kind)
                        KIND_NULL:
                        begin
                            r_status_next = STS_NULL_FREE;
                        end
                        KIND_FREE:
                        begin
                            r_status_next = STS_FREED;
                            mem_we        = 1'b1;
                            head_next     = cmd.index;
                            if (count_reg != COUNT_SAT)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        KIND_ALLOC:
                        begin
                            if (count_reg != '0)
                            begin
                                r_status_next = STS_ALLOCATED;
                                r_index_next  = head_reg;
                                count_next    = count_reg - COUNT_W'(1);
                                mem_re        = 1'b1;
                                state_next    = S_POP;
                            end
                            else if ((fresh_reg == '0) && (pages_reg >= PAGE_W'(MAX_PAGES)))
                            begin
                                r_status_next = STS_NO_MEMORY;
                            end
                            else
                            begin
                                r_status_next = STS_ALLOCATED;
                                r_index_next  = fresh_sum[IDX_W-1:0];
                                fresh_next    = fresh_sel;
                                if (fresh_reg == '0)
                                begin
                                    pages_next = pages_reg + PAGE_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            r_status_next = STS_NULL_FREE;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                head_next  = rd_data_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[cmd.index] <= head_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[head_reg];
        end
    end

    assign r_valid_next = r_load ? 1'b1 : (adv ? 1'b0 : r_valid_reg);
    assign o_valid_next = adv ? 1'b1 : (rsp.ready ? 1'b0 : o_valid_reg);
    assign prod = {{SIZE_W{1'b0}}, r_index_reg} * {{IDX_W{1'b0}}, size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            pages_reg   <= '0;
            size_reg    <= SIZE_W'(SIZE_RST);
            psize_reg   <= FRESH_W'(PAGE_RST);
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            pages_reg   <= pages_next;
            size_reg    <= size_next;
            psize_reg   <= psize_next;
            r_valid_reg <= r_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_status_reg <= r_status_next;
        r_index_reg  <= r_index_next;
        if (adv)
        begin
            o_status_reg <= r_status_reg;
            o_index_reg  <= r_index_reg;
            o_offset_reg <= (r_status_reg == STS_ALLOCATED) ? prod[OFFSET_W-1:0] : '0;
        end
    end

    assign rsp.valid         = o_valid_reg;
    assign rsp.status        = o_status_reg;
    assign rsp.granted_index = o_index_reg;
    assign rsp.byte_offset   = o_offset_reg;

endmodule

### sv/fbpa_checker.sv
module fbpa_checker
    import fbpa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [IDX_W-1:0]    rsp_granted_index,
    input logic [OFFSET_W-1:0] rsp_byte_offset
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_granted_index) && $stable(rsp_byte_offset))
        else $error("response changed while stalled");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STS_ALLOCATED)
            |-> (rsp_granted_index == '0) && (rsp_byte_offset == '0))
        else $error("non-allocation response carries index or offset");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    a_reset_release: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response valid straight after reset");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_granted_index (rsp.granted_index),
    .rsp_byte_offset   (rsp.byte_offset)
);
